### rtl/core/tbrl_pkg.sv
// package for the token bucket rate limiter
// shared widths, command and register codes, divide-by-1000 constants and stage types
// no dependencies
package tbrl_pkg;

  // default sizes of the stored state
  localparam int LEVEL_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_DEF  = 32;

  // fixed port widths
  localparam int CMD_W       = 3;
  localparam int VAL_W       = 31;
  localparam int NOW_W       = 32;
  localparam int CFG_W       = 31;
  localparam int REPORT_W    = 32;
  localparam int CFG_INDEX_W = 1;

  // request commands
  localparam logic [CMD_W-1:0] CMD_TRY_CONSUME = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CONSUME     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_AVAILABLE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INIT        = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REARM       = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEVEL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_RATE = 1'd1;

  // timing constants
  localparam int REFILL_GAP_MS = 100;
  localparam int MS_PER_SEC    = 1000;
  localparam int MS_LOG2_CEIL  = 10;

  // fill_rate = FQ * 1000 + FR
  localparam int FQ_W = 22;
  localparam int FR_W = 10;

  // fill_rate / 1000 by reciprocal, exact for 31-bit operands
  localparam int                      RATE_PROD_W   = 63;
  localparam int                      RATE_RECIP_SH = 41;
  localparam logic [RATE_PROD_W-1:0]  RATE_RECIP    = 63'd2199023256;

  // (fr * r) / 1000 by reciprocal, exact for 20-bit operands
  localparam int                       SMALL_IN_W     = 2 * FR_W;
  localparam int                       SMALL_PROD_W   = 41;
  localparam int                       SMALL_RECIP_SH = 30;
  localparam logic [SMALL_PROD_W-1:0]  SMALL_RECIP    = 41'd1073742;

  // refill amount is TIME_WIDTH + ADD_EXTRA bits wide
  localparam int ADD_EXTRA = 21;

  // saturation bounds of the reported level
  localparam logic signed [REPORT_W-1:0] REPORT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [REPORT_W-1:0] REPORT_MIN = 32'sh8000_0000;

  // reported value when shaping is off
  localparam logic [VAL_W-1:0] AVAIL_ALL = '1;

  // register load enables of the pipeline
  typedef struct packed {
    logic ld0;
    logic ld1;
    logic ld2;
    logic ld3;
    logic ldo;
  } pipe_en_t;

  // fill rate split for the refill multiply
  typedef struct packed {
    logic            on;
    logic [FQ_W-1:0] fq;
    logic [FR_W-1:0] fr;
  } rate_split_t;

  // command and value carried down the pipeline
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] val;
  } item_t;

endpackage

### rtl/core/token_bucket_rate_limiter.sv
// token bucket rate limiter, top level
// a request passes the stage 0 to 3 registers and then the result register, which drives rsp_valid
// throughput: one request per cycle while rsp_stall is low; the level update in the last stage is combinational
// reset: synchronous, clears the pipeline, token level, refill time and both registers
// the refill amount is built over three stages by splitting elapsed and rate by 1000
// depends on tbrl_pkg, tbrl_cfg, tbrl_ctrl, tbrl_refill, tbrl_level
module token_bucket_rate_limiter #(
  parameter int LEVEL_WIDTH = tbrl_pkg::LEVEL_WIDTH_DEF,
  parameter int TIME_WIDTH  = tbrl_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tbrl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tbrl_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [tbrl_pkg::CMD_W-1:0]        command,
  input  logic [tbrl_pkg::VAL_W-1:0]        value,
  input  logic [tbrl_pkg::NOW_W-1:0]        now_ms,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              granted,
  output logic [tbrl_pkg::VAL_W-1:0]        avail_value,
  output logic [tbrl_pkg::REPORT_W-1:0]     level_now
);
  import tbrl_pkg::*;

  localparam int ADD_W = TIME_WIDTH + ADD_EXTRA;

  pipe_en_t         en;
  rate_split_t      rate;
  logic [CFG_W-1:0] max_level;
  item_t            s3_item;
  logic             s3_refill;
  logic [ADD_W-1:0] s3_add;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  tbrl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .max_level (max_level),
    .rate      (rate)
  );

  tbrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .rsp_stall (rsp_stall),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .en        (en)
  );

  tbrl_refill #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_refill (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .command   (command),
    .value     (value),
    .now_ms    (now_ms),
    .rate      (rate),
    .s3_item   (s3_item),
    .s3_refill (s3_refill),
    .s3_add    (s3_add)
  );

  tbrl_level #(
    .LEVEL_WIDTH (LEVEL_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_level (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .s3_item     (s3_item),
    .s3_refill   (s3_refill),
    .s3_add      (s3_add),
    .max_level   (max_level),
    .rate        (rate),
    .granted     (granted),
    .avail_value (avail_value),
    .level_now   (level_now)
  );

endmodule

### rtl/core/tbrl_cfg.sv
// configuration registers of the token bucket rate limiter
// holds max_level and fill_rate, and splits fill_rate into quotient and remainder by 1000
// depends on tbrl_pkg
module tbrl_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [tbrl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tbrl_pkg::CFG_W-1:0]          cfg_data,
  output logic [tbrl_pkg::CFG_W-1:0]          max_level,
  output tbrl_pkg::rate_split_t               rate
);
  import tbrl_pkg::*;

  logic [CFG_W-1:0]       fill_rate;
  logic [FQ_W-1:0]        fq;
  logic [FR_W-1:0]        fr;
  logic [RATE_PROD_W-1:0] fq_prod;
  logic [CFG_W-1:0]       fq_ms;

  // quotient of the written rate by 1000
  assign fq_prod = RATE_PROD_W'(cfg_data) * RATE_RECIP;

  // remainder is registered in the cycle after the write
  assign fq_ms = CFG_W'(fq) * CFG_W'(MS_PER_SEC);

  // register writes, one transaction per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      max_level <= '0;
      fill_rate <= '0;
      fq        <= '0;
      fr        <= '0;
    end else begin
      fr <= FR_W'(fill_rate - fq_ms);
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MAX_LEVEL: begin
            max_level <= cfg_data;
          end
          REG_FILL_RATE: begin
            fill_rate <= cfg_data;
            fq        <= fq_prod[RATE_RECIP_SH+FQ_W-1:RATE_RECIP_SH];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign rate.on = (fill_rate != '0);
  assign rate.fq = fq;
  assign rate.fr = fr;

endmodule

### rtl/core/tbrl_ctrl.sv
// pipeline control of the token bucket rate limiter
// keeps the stage valid bits and the load enables, bubbles collapse, stall passes back through full stages
// depends on tbrl_pkg
module tbrl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                rsp_stall,
  output logic                req_stall,
  output logic                rsp_valid,
  output tbrl_pkg::pipe_en_t  en
);
  import tbrl_pkg::*;

  logic v0;
  logic v1;
  logic v2;
  logic v3;
  logic vout;
  logic take0;
  logic take1;
  logic take2;
  logic take3;
  logic take_out;

  // a stage can take a new item when empty or when its item moves on
  assign take_out = !vout || !rsp_stall;
  assign take3    = !v3 || take_out;
  assign take2    = !v2 || take3;
  assign take1    = !v1 || take2;
  assign take0    = !v0 || take1;

  assign en.ld0 = req_valid && take0;
  assign en.ld1 = v0 && take1;
  assign en.ld2 = v1 && take2;
  assign en.ld3 = v2 && take3;
  assign en.ldo = v3 && take_out;

  assign req_stall = !take0;
  assign rsp_valid = vout;

  // stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (take0)    v0   <= req_valid;
      if (take1)    v1   <= v0;
      if (take2)    v2   <= v1;
      if (take3)    v3   <= v2;
      if (take_out) vout <= v3;
    end
  end

  // the input only stalls with every stage full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (v0 && v1 && v2 && v3 && vout))
    else $error("input stalled with a free stage");

  // an unstalled output always takes what stage three held
  a_out_moves: assert property (@(posedge clk) disable iff (rst)
    (vout && !rsp_stall) |=> (rsp_valid == $past(v3)))
    else $error("output register did not advance");

endmodule

### rtl/core/tbrl_refill.sv
// refill amount pipeline of the token bucket rate limiter
// stages 0 to 3: time difference and refill decision, then fill_rate*elapsed/1000
// depends on tbrl_pkg
module tbrl_refill #(
  parameter int TIME_WIDTH = tbrl_pkg::TIME_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  tbrl_pkg::pipe_en_t                           en,
  input  logic [tbrl_pkg::CMD_W-1:0]                   command,
  input  logic [tbrl_pkg::VAL_W-1:0]                   value,
  input  logic [tbrl_pkg::NOW_W-1:0]                   now_ms,
  input  tbrl_pkg::rate_split_t                        rate,
  output tbrl_pkg::item_t                              s3_item,
  output logic                                         s3_refill,
  output logic [TIME_WIDTH+tbrl_pkg::ADD_EXTRA-1:0]    s3_add
);
  import tbrl_pkg::*;

  // elapsed time is positive, so N bits carry it
  localparam int N     = TIME_WIDTH - 1;
  localparam int Q_W   = N - MS_LOG2_CEIL + 1;
  localparam int ADD_W = TIME_WIDTH + ADD_EXTRA;
  localparam int FQD_W = N + FQ_W;
  localparam int FRQ_W = N + 1;
  localparam int QP_W  = 2 * N + 1;
  localparam int RK    = N + MS_LOG2_CEIL + 1;
  localparam logic [RK-1:0] ONE_K   = 1;
  localparam logic [RK-1:0] RECIP_K =
    ((ONE_K << (N + MS_LOG2_CEIL)) + RK'(MS_PER_SEC - 1)) / RK'(MS_PER_SEC);
  localparam logic [N:0] D_RECIP = RECIP_K[N:0];

  logic [TIME_WIDTH-1:0] last_refill;

  item_t                  s0_item;
  logic [TIME_WIDTH-1:0]  s0_now;
  item_t                  s1_item;
  logic                   s1_refill;
  logic [N-1:0]           s1_d;
  logic [Q_W-1:0]         s1_q;
  logic [FQD_W-1:0]       s1_fqd;
  item_t                  s2_item;
  logic                   s2_refill;
  logic [SMALL_IN_W-1:0]  s2_frr;
  logic [FRQ_W-1:0]       s2_frq;
  logic [FQD_W-1:0]       s2_fqd;

  logic [TIME_WIDTH-1:0]  diff;
  logic                   late;
  logic                   fill_cmd;
  logic                   refill_next;
  logic                   stamp;
  logic [N-1:0]           d;
  logic [QP_W-1:0]        q_prod;
  logic [FQD_W-1:0]       fqd_next;
  logic [N-1:0]           q_ms;
  logic [N-1:0]           r_full;
  logic [SMALL_IN_W-1:0]  frr_next;
  logic [FRQ_W-1:0]       frq_next;
  logic [SMALL_PROD_W-1:0] low_prod;
  logic [FR_W-1:0]        low_term;
  logic [ADD_W-1:0]       add_next;

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en.ld0) begin
      s0_item.cmd <= command;
      s0_item.val <= value;
      s0_now      <= TIME_WIDTH'(now_ms);
    end
  end

  // time since the last refill, read as signed
  assign diff     = s0_now - last_refill;
  assign late     = !diff[TIME_WIDTH-1] && (diff > TIME_WIDTH'(REFILL_GAP_MS));
  assign fill_cmd = (s0_item.cmd == CMD_TRY_CONSUME) || (s0_item.cmd == CMD_CONSUME) ||
                    (s0_item.cmd == CMD_AVAILABLE);
  assign refill_next = rate.on && fill_cmd && late;
  assign stamp       = refill_next || (s0_item.cmd == CMD_INIT) ||
                       (s0_item.cmd == CMD_REARM);

  // elapsed split by 1000, and the high part of the product
  assign d        = diff[N-1:0];
  assign q_prod   = QP_W'(d) * QP_W'(D_RECIP);
  assign fqd_next = FQD_W'(d) * FQD_W'(rate.fq);

  // refill time stamp, updated as the item leaves stage 0
  always_ff @(posedge clk) begin
    if (rst) begin
      last_refill <= '0;
    end else if (en.ld1 && stamp) begin
      last_refill <= s0_now;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en.ld1) begin
      s1_item   <= s0_item;
      s1_refill <= refill_next;
      s1_d      <= d;
      s1_q      <= q_prod[QP_W-1:N+MS_LOG2_CEIL];
      s1_fqd    <= fqd_next;
    end
  end

  // remainder of elapsed by 1000, and the cross terms
  assign q_ms     = N'(s1_q) * N'(MS_PER_SEC);
  assign r_full   = s1_d - q_ms;
  assign frr_next = SMALL_IN_W'(rate.fr) * SMALL_IN_W'(r_full[FR_W-1:0]);
  assign frq_next = FRQ_W'(rate.fr) * FRQ_W'(s1_q);

  // stage 2
  always_ff @(posedge clk) begin
    if (en.ld2) begin
      s2_item   <= s1_item;
      s2_refill <= s1_refill;
      s2_frr    <= frr_next;
      s2_frq    <= frq_next;
      s2_fqd    <= s1_fqd;
    end
  end

  // low term divided by 1000, then the full refill amount
  assign low_prod = SMALL_PROD_W'(s2_frr) * SMALL_RECIP;
  assign low_term = low_prod[SMALL_RECIP_SH+FR_W-1:SMALL_RECIP_SH];
  assign add_next = ADD_W'(s2_fqd) + ADD_W'(s2_frq) + ADD_W'(low_term);

  // stage 3
  always_ff @(posedge clk) begin
    if (en.ld3) begin
      s3_item   <= s2_item;
      s3_refill <= s2_refill;
      s3_add    <= add_next;
    end
  end

  // the time stamp moves only with an item leaving stage 0
  a_stamp_hold: assert property (@(posedge clk) disable iff (rst)
    !en.ld1 |=> $stable(last_refill))
    else $error("refill time changed without a transaction");

  // init always records its time
  a_init_stamp: assert property (@(posedge clk) disable iff (rst)
    (en.ld1 && (s0_item.cmd == CMD_INIT)) |=> (last_refill == $past(s0_now)))
    else $error("init did not record the time");

endmodule

### rtl/core/tbrl_level.sv
// token level update and result register of the token bucket rate limiter
// applies the refill, executes the command and saturates the reported level
// depends on tbrl_pkg
module tbrl_level #(
  parameter int LEVEL_WIDTH = tbrl_pkg::LEVEL_WIDTH_DEF,
  parameter int TIME_WIDTH  = tbrl_pkg::TIME_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  tbrl_pkg::pipe_en_t                           en,
  input  tbrl_pkg::item_t                              s3_item,
  input  logic                                         s3_refill,
  input  logic [TIME_WIDTH+tbrl_pkg::ADD_EXTRA-1:0]    s3_add,
  input  logic [tbrl_pkg::CFG_W-1:0]                   max_level,
  input  tbrl_pkg::rate_split_t                        rate,
  output logic                                         granted,
  output logic [tbrl_pkg::VAL_W-1:0]                   avail_value,
  output logic [tbrl_pkg::REPORT_W-1:0]                level_now
);
  import tbrl_pkg::*;

  localparam int LW    = LEVEL_WIDTH;
  localparam int ADD_W = TIME_WIDTH + ADD_EXTRA;
  localparam int XW    = ((LW > REPORT_W) ? LW : REPORT_W) + 2;
  localparam int CW    = (ADD_W > LW + 1) ? ADD_W : LW + 1;
  localparam logic signed [LW-1:0] LVL_MAX = {1'b0, {(LW-1){1'b1}}};
  localparam logic signed [LW-1:0] LVL_MIN = {1'b1, {(LW-1){1'b0}}};

  logic signed [LW-1:0]   level;
  logic signed [LW-1:0]   level_next;
  logic signed [XW-1:0]   ml_x;
  logic signed [XW-1:0]   lmax_x;
  logic signed [XW-1:0]   cap_x;
  logic signed [LW-1:0]   cap;
  logic signed [LW:0]     headroom;
  logic                   full;
  logic signed [LW-1:0]   lvl1;
  logic signed [XW-1:0]   lvl1_x;
  logic signed [XW-1:0]   level_x;
  logic signed [XW-1:0]   val_x;
  logic signed [XW-1:0]   sub_x;
  logic signed [XW-1:0]   next_x;
  logic                   grant_next;
  logic [VAL_W-1:0]       avail_next;
  logic [REPORT_W-1:0]    report_next;

  // ceiling: max_level limited to what the level can hold
  assign ml_x   = $signed(XW'(max_level));
  assign lmax_x = XW'(LVL_MAX);
  assign cap_x  = (ml_x < lmax_x) ? ml_x : lmax_x;
  assign cap    = cap_x[LW-1:0];

  // refill: add, or go to the cap when the amount does not fit
  assign headroom = (LW+1)'(cap) - (LW+1)'(level);
  assign full     = (level >= cap) || (CW'(s3_add) >= CW'($unsigned(headroom)));
  assign lvl1     = !s3_refill ? level : (full ? cap : level + LW'(s3_add));

  assign lvl1_x  = XW'(lvl1);
  assign level_x = XW'(level);
  assign val_x   = $signed(XW'(s3_item.val));
  assign sub_x   = lvl1_x - val_x;

  // command execution
  always_comb begin
    level_next = level;
    grant_next = 1'b1;
    avail_next = '0;
    unique case (s3_item.cmd)
      CMD_TRY_CONSUME: begin
        if (rate.on) begin
          if (lvl1_x >= val_x) begin
            level_next = sub_x[LW-1:0];
          end else begin
            level_next = lvl1;
            grant_next = 1'b0;
          end
        end
      end
      CMD_CONSUME: begin
        if (rate.on) begin
          if (sub_x < XW'(LVL_MIN)) begin
            level_next = LVL_MIN;
          end else begin
            level_next = sub_x[LW-1:0];
          end
          grant_next = !level_next[LW-1];
        end
      end
      CMD_AVAILABLE: begin
        if (rate.on) begin
          level_next = lvl1;
          if (lvl1_x > val_x) avail_next = lvl1_x[VAL_W-1:0];
        end else begin
          avail_next = AVAIL_ALL;
        end
      end
      CMD_INIT: begin
        level_next = (val_x < cap_x) ? val_x[LW-1:0] : cap;
      end
      CMD_REARM: begin
        level_next = (level_x > cap_x) ? cap : level;
      end
      default: begin
      end
    endcase
  end

  // level report saturated to 32 bits
  assign next_x = XW'(level_next);
  always_comb begin
    if (next_x > XW'(REPORT_MAX)) begin
      report_next = REPORT_MAX;
    end else if (next_x < XW'(REPORT_MIN)) begin
      report_next = REPORT_MIN;
    end else begin
      report_next = next_x[REPORT_W-1:0];
    end
  end

  // token level state
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (en.ldo) begin
      level <= level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en.ldo) begin
      granted     <= grant_next;
      avail_value <= avail_next;
      level_now   <= report_next;
    end
  end

  // only a shaped consume can be refused
  a_deny_cmd: assert property (@(posedge clk) disable iff (rst)
    (en.ldo && !grant_next) |->
      (rate.on && ((s3_item.cmd == CMD_TRY_CONSUME) || (s3_item.cmd == CMD_CONSUME))))
    else $error("refusal on a command that always grants");

  // init never leaves the level above the cap
  a_init_cap: assert property (@(posedge clk) disable iff (rst)
    (en.ldo && (s3_item.cmd == CMD_INIT)) |=> (level <= $past(cap)))
    else $error("init level above the cap");

endmodule

### sim/token_bucket_rate_limiter_tb.sv
// testbench for the token bucket rate limiter: directed and random request traffic
// checked against an in-bench bucket predictor; depends on tbrl_pkg and token_bucket_rate_limiter
`timescale 1ns / 100ps

module token_bucket_rate_limiter_tb;
  import tbrl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam longint LEVEL_TOP    = 64'sh0000_0000_7FFF_FFFF;
  localparam longint LEVEL_BOTTOM = -LEVEL_TOP - 1;
  localparam logic [VAL_W-1:0] VAL_ALL = '1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_REARM + 1'b1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  typedef struct {
    logic              granted;
    logic [VAL_W-1:0]  avail;
    logic [REPORT_W-1:0] level;
  } bucket_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [CMD_W-1:0] command = '0;
  logic [VAL_W-1:0] value = '0;
  logic [NOW_W-1:0] now_ms = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic granted;
  logic [VAL_W-1:0] avail_value;
  logic [REPORT_W-1:0] level_now;

  // bucket predictor state
  logic [CFG_W-1:0] cfg_max_level = '0;
  logic [CFG_W-1:0] cfg_fill_rate = '0;
  longint bucket_level = 0;
  logic [NOW_W-1:0] last_refill_ms = '0;

  bucket_result_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned req_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  logic hold_rsp = 1'b0;
  logic [NOW_W-1:0] clock_ms = '0;
  int unsigned amount_span = 64;

  token_bucket_rate_limiter u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .command     (command),
    .value       (value),
    .now_ms      (now_ms),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .granted     (granted),
    .avail_value (avail_value),
    .level_now   (level_now)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("token_bucket_rate_limiter_tb NOT OK");
      $finish;
    end
  end

  // receiver back-pressure, random or held off
  always @(posedge clk) begin
    rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t ns: %s", $realtime, what);
  endtask

  // refill once more than the gap has passed, capped at max_level
  function automatic void refill_bucket(input logic [NOW_W-1:0] now);
    logic [NOW_W-1:0] elapsed;
    longint cap;
    longint add;
    elapsed = now - last_refill_ms;
    cap = cfg_max_level;
    if (elapsed[NOW_W-1] || elapsed <= REFILL_GAP_MS) return;
    last_refill_ms = now;
    add = (64'(cfg_fill_rate) * 64'(elapsed)) / MS_PER_SEC;
    if (cap <= bucket_level || add >= cap - bucket_level) bucket_level = cap;
    else bucket_level += add;
  endfunction

  // expected result of one request, updating the predicted bucket
  function automatic bucket_result_t bucket_step(input logic [CMD_W-1:0] cmd,
                                                 input logic [VAL_W-1:0] val,
                                                 input logic [NOW_W-1:0] now);
    bucket_result_t r;
    longint amount;
    longint cap;
    longint rep;
    logic shaping;
    amount = val;
    cap = cfg_max_level;
    shaping = (cfg_fill_rate != 0);
    r.granted = 1'b1;
    r.avail = '0;
    case (cmd)
      CMD_TRY_CONSUME: begin
        if (shaping) begin
          refill_bucket(now);
          if (bucket_level >= amount) bucket_level -= amount;
          else r.granted = 1'b0;
        end
      end
      CMD_CONSUME: begin
        if (shaping) begin
          refill_bucket(now);
          if (bucket_level < LEVEL_BOTTOM + amount) bucket_level = LEVEL_BOTTOM;
          else bucket_level -= amount;
          r.granted = (bucket_level >= 0);
        end
      end
      CMD_AVAILABLE: begin
        if (!shaping) begin
          r.avail = AVAIL_ALL;
        end else begin
          refill_bucket(now);
          if (bucket_level > amount) r.avail = bucket_level[VAL_W-1:0];
        end
      end
      CMD_INIT: begin
        bucket_level = (amount < cap) ? amount : cap;
        last_refill_ms = now;
      end
      CMD_REARM: begin
        if (bucket_level > cap) bucket_level = cap;
        last_refill_ms = now;
      end
      default: ;
    endcase
    rep = bucket_level;
    if (rep > LEVEL_TOP) rep = LEVEL_TOP;
    if (rep < LEVEL_BOTTOM) rep = LEVEL_BOTTOM;
    r.level = rep[REPORT_W-1:0];
    return r;
  endfunction

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    bucket_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with none expected, level_now %0d",
                                $signed(level_now)));
      end else begin
        want = pending_results.pop_front();
        if (granted !== want.granted)
          flag_mismatch($sformatf("granted %b, expected %b", granted, want.granted));
        if (avail_value !== want.avail)
          flag_mismatch($sformatf("avail_value %0d, expected %0d", avail_value, want.avail));
        if (level_now !== want.level)
          flag_mismatch($sformatf("level_now %0d, expected %0d",
                                  $signed(level_now), $signed(want.level)));
      end
    end
  end

  // one request transaction, with random idle cycles ahead of it
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                              input logic [NOW_W-1:0] now);
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    value <= val;
    now_ms <= now;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(bucket_step(cmd, val, now));
  endtask

  // stop sending and wait for every expected result
  task automatic settle_pipeline();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAX_LEVEL) cfg_max_level = data;
    else cfg_fill_rate = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] max_lvl, input logic [CFG_W-1:0] rate);
    settle_pipeline();
    write_reg(REG_MAX_LEVEL, max_lvl);
    write_reg(REG_FILL_RATE, rate);
    amount_span = (max_lvl >> 2) + 64;
  endtask

  function automatic logic [VAL_W-1:0] rand_amount();
    case ($urandom_range(9))
      0: return VAL_W'($urandom());
      1: return '0;
      2: return VAL_ALL;
      default: return VAL_W'($urandom_range(amount_span, 0));
    endcase
  endfunction

  // mostly small forward steps, some at the refill gap, backwards or far off
  function automatic logic [NOW_W-1:0] next_time();
    case ($urandom_range(19))
      0: clock_ms = $urandom();
      1: clock_ms = clock_ms - $urandom_range(300, 1);
      2: clock_ms = clock_ms + REFILL_GAP_MS;
      3: clock_ms = clock_ms + REFILL_GAP_MS + 1;
      4: clock_ms = clock_ms + $urandom_range(32'h7FFF_FFFF, 1000);
      default: clock_ms = clock_ms + $urandom_range(250, 0);
    endcase
    return clock_ms;
  endfunction

  function automatic logic [CFG_W-1:0] rand_max_level();
    case ($urandom_range(3))
      0: return '0;
      1: return CFG_W'($urandom_range(5000, 1));
      2: return CFG_W'($urandom());
      default: return VAL_ALL;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_fill_rate();
    case ($urandom_range(4))
      0: return '0;
      1: return CFG_W'($urandom_range(50, 1));
      2: return CFG_W'($urandom_range(100000, 51));
      3: return CFG_W'($urandom());
      default: return VAL_ALL;
    endcase
  endfunction

  // well-formed usage with some rearms, inits and unused commands mixed in
  task automatic run_traffic(input int count);
    int pick;
    send_request(CMD_INIT, rand_amount(), next_time());
    for (int i = 1; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) send_request(CMD_INIT, rand_amount(), next_time());
      else if (pick < 7) send_request(CMD_REARM, rand_amount(), next_time());
      else if (pick < 10)
        send_request(CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)),
                     rand_amount(), next_time());
      else if (pick < 45) send_request(CMD_TRY_CONSUME, rand_amount(), next_time());
      else if (pick < 75) send_request(CMD_CONSUME, rand_amount(), next_time());
      else send_request(CMD_AVAILABLE, rand_amount(), next_time());
    end
  endtask

  // registers at reset: shaping off
  task automatic test_shaping_off();
    send_request(CMD_TRY_CONSUME, VAL_ALL, '0);
    send_request(CMD_CONSUME, VAL_ALL, '1);
    send_request(CMD_AVAILABLE, '0, 50);
    send_request(CMD_INIT, VAL_ALL, 1000);
    send_request(CMD_REARM, '0, 2000);
    send_request(CMD_UNUSED_LO, VAL_ALL, 3000);
    send_request(CMD_UNUSED_HI, '0, 4000);
  endtask

  // refill gap edge, refill overflow, consume underflow, time running backwards
  task automatic test_refill_limits();
    set_config(VAL_ALL, VAL_ALL);
    send_request(CMD_INIT, VAL_ALL, 1000);
    send_request(CMD_TRY_CONSUME, VAL_ALL, 1050);
    send_request(CMD_TRY_CONSUME, 1, 1100);
    send_request(CMD_AVAILABLE, '0, 1101);
    send_request(CMD_CONSUME, VAL_ALL, 1150);
    send_request(CMD_CONSUME, VAL_ALL, 1200);
    send_request(CMD_CONSUME, VAL_ALL, 1250);
    send_request(CMD_TRY_CONSUME, '0, 900);
    send_request(CMD_AVAILABLE, VAL_ALL, 32'h8000_0000 + 1101);
    send_request(CMD_CONSUME, '0, '1);
    send_request(CMD_TRY_CONSUME, 5, 32'h8000_044C);
  endtask

  // level above the cap: clamped by rearm and by refill
  task automatic test_cap_clamp();
    set_config(VAL_ALL, 1);
    send_request(CMD_INIT, VAL_ALL, 0);
    set_config(500, 1);
    send_request(CMD_REARM, '0, 10);
    set_config(VAL_ALL, 1);
    send_request(CMD_INIT, VAL_ALL, 20);
    set_config(300, 1000);
    send_request(CMD_AVAILABLE, '0, 121);
    send_request(CMD_CONSUME, 1000, 130);
    send_request(CMD_TRY_CONSUME, '0, 400);
    set_config('0, 1000);
    send_request(CMD_INIT, 5, 0);
    send_request(CMD_AVAILABLE, '0, 200);
  endtask

  task automatic test_random_traffic();
    req_idle_pct = 29;
    rsp_stall_pct <= 29;
    for (int p = 0; p < 5; p++) begin
      set_config(rand_max_level(), rand_fill_rate());
      run_traffic(100);
    end
  endtask

  // no idling on either side
  task automatic test_full_rate();
    set_config(CFG_W'($urandom()), CFG_W'($urandom_range(100000, 1)));
    req_idle_pct = 0;
    rsp_stall_pct <= 0;
    run_traffic(100);
  endtask

  // receiver held off as requests keep coming, sender waits for all results, then more traffic
  task automatic test_backpressure();
    set_config(CFG_W'($urandom_range(5000, 1)), CFG_W'($urandom_range(50, 1)));
    req_idle_pct = 0;
    fork
      begin
        hold_rsp <= 1'b1;
        repeat (80) @(posedge clk);
        hold_rsp <= 1'b0;
      end
    join_none
    run_traffic(60);
    settle_pipeline();
    req_idle_pct = 29;
    rsp_stall_pct <= 29;
    run_traffic(20);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_shaping_off();
    test_refill_limits();
    test_cap_clamp();
    test_random_traffic();
    test_full_rate();
    test_backpressure();
    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("token_bucket_rate_limiter_tb OK");
    end else begin
      $display("token_bucket_rate_limiter_tb NOT OK");
    end
    $finish;
  end

endmodule
